// ===== hdl/hmpf_pkg.sv =====
package hmpf_pkg;

    localparam int PACKET_BYTES = 64;
    localparam int POS_W        = $clog2(PACKET_BYTES);
    localparam int CFG_IDX_W    = 2;

    typedef logic [POS_W-1:0] t_pos;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_WORD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_BYTE     = CFG_IDX_W'(1);

    localparam logic [15:0] CHANNEL_WORD_RST = 16'h0101;
    localparam logic [7:0]  TAG_BYTE_RST     = 8'h05;

    // header slots
    localparam int HDR_CHAN_HI = 0;
    localparam int HDR_CHAN_LO = 1;
    localparam int HDR_TAG     = 2;
    localparam int HDR_SEQ_HI  = 3;
    localparam int HDR_SEQ_LO  = 4;
    localparam int HDR_LEN_HI  = 5;
    localparam int HDR_LEN_LO  = 6;

    localparam int HDR_BYTES_FIRST = 7;
    localparam int HDR_BYTES_NEXT  = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one classified payload byte
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] len;
        logic        first;
        logic        last;
    } t_cmd;

endpackage

// ===== hdl/hmpf_in_if.sv =====
interface hmpf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [15:0] message_length;

    modport source(output valid, output payload_byte, output message_length, input ready);
    modport sink(input valid, input payload_byte, input message_length, output ready);
endinterface

// ===== hdl/hmpf_out_if.sv =====
interface hmpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       message_end;
    logic       run_last;

    modport source(output valid, output out_byte, output packet_end, output message_end,
                   output run_last, input ready);
    modport sink(input valid, input out_byte, input packet_end, input message_end,
                 input run_last, output ready);
endinterface

// ===== hdl/hmpf_cfg_if.sv =====
interface hmpf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hmpf_pkg::CFG_IDX_W-1:0]  index;
    logic [15:0]                     data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/hmpf_front.sv =====
module hmpf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hmpf_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output hmpf_pkg::t_cmd o_cmd
);

    logic [15:0] r_bytes_left;
    logic [15:0] n_bytes_left;
    logic        accept;
    logic        start;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign start      = (r_bytes_left == 16'd0);

    always_comb begin
        o_cmd.data   = i_in.payload_byte;
        o_cmd.len    = i_in.message_length;
        o_cmd.first  = start;
        n_bytes_left = r_bytes_left;
        o_push       = 1'b0;
        if (start) begin
            o_cmd.last = (i_in.message_length == 16'd1);
            if (accept && i_in.message_length != 16'd0) begin
                o_push       = 1'b1;
                n_bytes_left = i_in.message_length - 16'd1;
            end
        end else begin
            o_cmd.last = (r_bytes_left == 16'd1);
            if (accept) begin
                o_push       = 1'b1;
                n_bytes_left = r_bytes_left - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 16'd0;
        end else begin
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

// ===== hdl/hmpf_queue.sv =====
module hmpf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hmpf_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output hmpf_pkg::t_cmd o_head
);

    hmpf_pkg::t_cmd                r_mem [hmpf_pkg::QUEUE_DEPTH];
    logic [hmpf_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [hmpf_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [hmpf_pkg::QCNT_W-1:0]   r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == hmpf_pkg::QCNT_W'(hmpf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= hmpf_pkg::QCNT_W'(hmpf_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty && !i_push |=> o_empty)
        else $error("queue filled without push");

endmodule

// ===== hdl/hmpf_back.sv =====
module hmpf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  hmpf_pkg::t_cmd i_q_head,
    output logic           o_pop,
    hmpf_cfg_if.sink       i_cfg,
    hmpf_out_if.source     o_out
);

    typedef enum logic [1:0] {
        S_HDR,
        S_DATA,
        S_PAD
    } t_stage;

    hmpf_pkg::t_cmd r_cmd;
    logic           r_busy;
    t_stage         r_stage;
    hmpf_pkg::t_pos r_pos;
    logic [15:0]    r_seq;
    logic [15:0]    r_chan;
    logic [7:0]     r_tag;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_pend;
    logic           r_out_mend;
    logic           r_out_last;

    logic           out_ld;
    logic           emit;
    logic           done;
    logic [7:0]     e_byte;
    logic           e_pend;
    logic           e_mend;
    logic           e_last;
    t_stage         n_stage;
    hmpf_pkg::t_pos n_pos;
    hmpf_pkg::t_pos pos_after;
    hmpf_pkg::t_pos hdr_end;

    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.packet_end  = r_out_pend;
    assign o_out.message_end = r_out_mend;
    assign o_out.run_last    = r_out_last;

    assign out_ld    = !r_out_valid || o_out.ready;
    assign emit      = out_ld && r_busy;
    assign e_pend    = (r_pos == hmpf_pkg::t_pos'(hmpf_pkg::PACKET_BYTES - 1));
    assign n_pos     = e_pend ? '0 : r_pos + 1'b1;
    assign pos_after = emit ? n_pos : r_pos;
    assign o_pop     = !i_q_empty && (!r_busy || (emit && done));
    assign hdr_end   = r_cmd.first ? hmpf_pkg::t_pos'(hmpf_pkg::HDR_BYTES_FIRST - 1)
                                   : hmpf_pkg::t_pos'(hmpf_pkg::HDR_BYTES_NEXT - 1);

    always_comb begin
        e_byte  = 8'h00;
        e_mend  = 1'b0;
        e_last  = 1'b0;
        done    = 1'b0;
        n_stage = r_stage;
        case (r_stage)
            S_HDR: begin
                case (r_pos)
                    hmpf_pkg::t_pos'(hmpf_pkg::HDR_CHAN_HI): e_byte = r_chan[15:8];
                    hmpf_pkg::t_pos'(hmpf_pkg::HDR_CHAN_LO): e_byte = r_chan[7:0];
                    hmpf_pkg::t_pos'(hmpf_pkg::HDR_TAG):     e_byte = r_tag;
                    hmpf_pkg::t_pos'(hmpf_pkg::HDR_SEQ_HI):  e_byte = r_seq[15:8];
                    hmpf_pkg::t_pos'(hmpf_pkg::HDR_SEQ_LO):  e_byte = r_seq[7:0];
                    hmpf_pkg::t_pos'(hmpf_pkg::HDR_LEN_HI):  e_byte = r_cmd.len[15:8];
                    hmpf_pkg::t_pos'(hmpf_pkg::HDR_LEN_LO):  e_byte = r_cmd.len[7:0];
                    default:                                 e_byte = 8'h00;
                endcase
                if (r_pos == hdr_end) begin
                    n_stage = S_DATA;
                end
            end
            S_DATA: begin
                e_byte = r_cmd.data;
                e_mend = e_pend && r_cmd.last;
                done   = !r_cmd.last || e_pend;
                e_last = done;
                if (!done) begin
                    n_stage = S_PAD;
                end
            end
            S_PAD: begin
                e_mend = e_pend;
                done   = e_pend;
                e_last = e_pend;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_stage     <= S_HDR;
            r_pos       <= '0;
            r_seq       <= 16'd0;
            r_chan      <= hmpf_pkg::CHANNEL_WORD_RST;
            r_tag       <= hmpf_pkg::TAG_BYTE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    hmpf_pkg::CFG_CHANNEL_WORD: r_chan <= i_cfg.data;
                    hmpf_pkg::CFG_TAG_BYTE:     r_tag  <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
            if (out_ld) begin
                r_out_valid <= emit;
                r_out_byte  <= e_byte;
                r_out_pend  <= e_pend;
                r_out_mend  <= e_mend;
                r_out_last  <= e_last;
            end
            if (emit) begin
                r_pos <= n_pos;
            end
            // a new message restarts the packet count
            if (o_pop && i_q_head.first) begin
                r_seq <= 16'd0;
            end else if (emit && e_pend) begin
                r_seq <= r_seq + 16'd1;
            end
            if (o_pop) begin
                r_cmd   <= i_q_head;
                r_busy  <= 1'b1;
                r_stage <= (pos_after == '0) ? S_HDR : S_DATA;
            end else if (emit) begin
                r_stage <= n_stage;
                if (done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    a_mend_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_mend |-> r_out_pend && r_out_last)
        else $error("message end off a packet boundary");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && e_pend |=> r_pos == '0)
        else $error("position did not wrap at packet end");

    a_first_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_q_head.first |-> pos_after == '0)
        else $error("new message started mid packet");

    a_pad_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_stage == S_PAD |-> r_cmd.last)
        else $error("padding outside final byte");

endmodule

// ===== hdl/hid_message_packet_framer.sv =====
// Frames a message byte stream into 64-byte packets: each packet opens with the channel
// word, tag byte and 16-bit sequence number (big-endian); the first packet also carries the
// 16-bit message length, and the final packet is zero padded. The message length is
// sampled on the first byte; a first byte with length zero is dropped. A two-entry queue
// separates the input classifier from the byte sequencer, which emits one byte per cycle
// while the output is ready; a payload byte is taken every cycle except on output stalls
// or when the queue fills while header bytes (5 or 7) or padding are sent. Results come
// from an output register; run_last marks the last byte caused by each input byte.
// Configuration writes take effect at once and are meant for idle periods.
module hid_message_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmpf_in_if.sink     i_in,
    hmpf_cfg_if.sink    i_cfg,
    hmpf_out_if.source  o_out
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    hmpf_pkg::t_cmd q_in;
    hmpf_pkg::t_cmd q_head;

    hmpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    hmpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    hmpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int SETTLE_CYCLES  = 32;
    localparam int OPEN_MSG_BYTES = 60;
    localparam logic [hmpf_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = hmpf_pkg::CFG_IDX_W'(2);

    // predicts the framed byte stream and holds the bytes still owed by the block
    class framed_stream_board;
        typedef struct packed {
            logic [7:0] out_byte;
            logic       packet_end;
            logic       message_end;
            logic       run_last;
        } t_framed;

        t_framed        expected_q[$];
        logic [15:0]    channel_word;
        logic [7:0]     tag_byte;
        hmpf_pkg::t_pos slot;
        logic [15:0]    packet_seq;
        logic [15:0]    bytes_left;
        int             errors;
        int             checked;
        int             payload_bytes;
        int             messages;

        function new();
            channel_word  = hmpf_pkg::CHANNEL_WORD_RST;
            tag_byte      = hmpf_pkg::TAG_BYTE_RST;
            slot          = '0;
            packet_seq    = '0;
            bytes_left    = '0;
            errors        = 0;
            checked       = 0;
            payload_bytes = 0;
            messages      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [hmpf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                hmpf_pkg::CFG_CHANNEL_WORD: channel_word = value;
                hmpf_pkg::CFG_TAG_BYTE:     tag_byte = value[7:0];
                default: ;
            endcase
        endfunction

        function void emit(logic [7:0] value, bit done);
            t_framed f;
            bit      closes;
            closes        = (slot == hmpf_pkg::t_pos'(hmpf_pkg::PACKET_BYTES - 1));
            f.out_byte    = value;
            f.packet_end  = closes;
            f.message_end = closes && done;
            f.run_last    = 1'b0;
            expected_q.push_back(f);
            if (closes) begin
                slot       = '0;
                packet_seq = packet_seq + 16'd1;
            end else begin
                slot = slot + hmpf_pkg::t_pos'(1);
            end
        endfunction

        function void frame_payload_byte(logic [7:0] data, logic [15:0] msg_len);
            bit      opening;
            t_framed tail;
            opening = 1'b0;
            if (bytes_left == 0) begin
                // a first byte with zero length is dropped without a trace
                if (msg_len == 0)
                    return;
                bytes_left = msg_len;
                packet_seq = '0;
                slot       = '0;
                opening    = 1'b1;
                messages++;
            end
            payload_bytes++;
            if (slot == 0) begin
                emit(channel_word[15:8], 1'b0);
                emit(channel_word[7:0], 1'b0);
                emit(tag_byte, 1'b0);
                emit(packet_seq[15:8], 1'b0);
                emit(packet_seq[7:0], 1'b0);
                if (opening) begin
                    emit(msg_len[15:8], 1'b0);
                    emit(msg_len[7:0], 1'b0);
                end
            end
            bytes_left = bytes_left - 16'd1;
            emit(data, bytes_left == 0);
            // zero pad the final packet
            if (bytes_left == 0)
                while (slot != 0)
                    emit(8'h00, 1'b1);
            tail = expected_q.pop_back();
            tail.run_last = 1'b1;
            expected_q.push_back(tail);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_framed_byte(logic [7:0] b, logic pend, logic mend, logic rlast);
            t_framed want;
            if (expected_q.size() == 0) begin
                $error("out_byte 0x%0h arrived with nothing outstanding", b);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("out_byte", want.out_byte, b);
            compare_field("packet_end", want.packet_end, pend);
            compare_field("message_end", want.message_end, mend);
            compare_field("run_last", want.run_last, rlast);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct = 26;
    int   recv_idle_pct = 64;

    framed_stream_board board = new();

    hmpf_in_if  in_ch();
    hmpf_cfg_if cfg_ch();
    hmpf_out_if out_ch();

    hid_message_packet_framer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_framed_byte(out_ch.out_byte, out_ch.packet_end,
                                    out_ch.message_end, out_ch.run_last);
    end

    // entered and left at a falling edge
    task automatic push_payload(input logic [7:0] data, input logic [15:0] msg_len);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.payload_byte   <= data;
        in_ch.message_length <= msg_len;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        board.frame_payload_byte(data, msg_len);
        @(negedge i_clk);
    endtask

    // length field only matters on the first byte, later ones carry junk
    task automatic send_message(input int unsigned length);
        for (int unsigned k = 0; k < length; k++)
            push_payload(8'($urandom_range(255)),
                         (k == 0) ? 16'(length) : 16'($urandom_range(65535)));
    endtask

    task automatic write_framer_reg(input logic [hmpf_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        board.set_register(idx, value);
        @(negedge i_clk);
    endtask

    task automatic configure_framer(input logic [15:0] chan, input logic [15:0] tag);
        write_framer_reg(hmpf_pkg::CFG_CHANNEL_WORD, chan);
        write_framer_reg(hmpf_pkg::CFG_TAG_BYTE, tag);
        write_framer_reg(CFG_SPARE_IDX, 16'($urandom_range(65535)));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle_framer();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int budget);
        int sent;
        int pick;
        int length;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(9);
            if (pick == 0)
                length = hmpf_pkg::PACKET_BYTES - hmpf_pkg::HDR_BYTES_FIRST;
            else if (pick == 1)
                length = $urandom_range(hmpf_pkg::PACKET_BYTES - hmpf_pkg::HDR_BYTES_FIRST - 2,
                                        hmpf_pkg::PACKET_BYTES - hmpf_pkg::HDR_BYTES_NEXT);
            else if (pick == 2)
                length = 0;
            else
                length = $urandom_range(1, 30);
            if (length == 0) begin
                push_payload(8'($urandom_range(255)), 16'h0000);
            end else begin
                send_message(length);
                sent += length;
            end
        end
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.payload_byte   = 8'h00;
        in_ch.message_length = 16'h0000;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = hmpf_pkg::CFG_CHANNEL_WORD;
        cfg_ch.data          = 16'h0000;
        i_rst_n              = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset register values
        push_payload(8'hFF, 16'h0000);
        push_payload(8'h00, 16'h0001);
        push_payload(8'hFF, 16'h0001);
        push_payload(8'hAA, 16'h0003);
        push_payload(8'h55, 16'hFFFF);
        push_payload(8'h80, 16'h0000);
        push_payload(8'h7F, 16'h0000);
        push_payload(8'h01, 16'h0002);
        push_payload(8'hFE, 16'h5555);
        settle_framer();

        configure_framer(16'h0000, 16'hFF00);
        run_random_phase(20);
        settle_framer();

        send_idle_pct = 64;
        recv_idle_pct = 26;
        configure_framer(16'hFFFF, 16'h00FF);
        run_random_phase(20);
        settle_framer();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure_framer(16'($urandom_range(65535)), 16'($urandom_range(65535)));
        run_random_phase(20);
        // longest message length, left open just after its second packet starts
        for (int unsigned k = 0; k < OPEN_MSG_BYTES; k++)
            push_payload(8'($urandom_range(255)),
                         (k == 0) ? 16'hFFFF : 16'($urandom_range(65535)));
        settle_framer();

        $display("covered %0d messages, %0d payload bytes, %0d framed bytes checked",
                 board.messages, board.payload_bytes, board.checked);
        $display("register sets: reset, all zero, all ones, random; lengths 1 to 59 and 65535");
        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
